// ----- hw/rtl/assert_macros.svh -----
// Assertion helper macros shared by the core and MAC RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FIQ_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FIQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/fir_iq_pkg.sv -----
// Shared types and constants of the I/Q FIR filter.
`default_nettype none

package fir_iq_pkg;

    localparam int unsigned MAX_TAPS_DEF = 64;
    localparam int unsigned DATA_W       = 16;
    localparam int unsigned CNT_W        = 7;
    localparam int unsigned IDX_W        = 6;
    localparam int unsigned PROD_W       = 2 * DATA_W;

    localparam logic [CNT_W-1:0] TAP_COUNT_RST = 7'd64;

    localparam logic OP_FILTER = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    // Sequencer to MAC control.
    typedef struct packed {
        logic clear;   // zero the accumulators
        logic rd_vld;  // memory read data is a live tap pair
    } t_mac_ctl;

endpackage

`default_nettype wire

// ----- hw/rtl/fir_filter_iq_core.sv -----
// Top level of the I/Q FIR filter: sequencer, position modulo and output register.
//
//   channel   direction  handshake                  payload
//   in        sink       i_in_valid / o_in_ready    i_op, i_coef_index, i_coef_value,
//                                                   i_sample_i, i_sample_q
//   out       source     o_out_valid / i_out_ready  o_out_i, o_out_q
//   cfg       sink       i_cfg_we (no wait)         i_cfg_wdata (tap_count)
//
// A load item is written while the sequencer stays idle. A filter item keeps the
// block busy after acceptance for AW = clog2(MAX_TAPS) steps of the restoring
// modulo, one history write, n issues (n the effective tap count) through the
// single shared MAC (one tap, both lanes, per cycle), the drain of the
// read/multiply/accumulate path and the load of the output register. Reset is
// synchronous, active low, and needs no clearing pass: valid bits make
// unwritten memory entries read as zero. A full output register stalls only the
// final load of the next result; input is taken whenever the sequencer is idle.
`default_nettype none

`include "assert_macros.svh"

module fir_filter_iq_core #(
    parameter int unsigned MAX_TAPS = fir_iq_pkg::MAX_TAPS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic                                 i_op,
    input  wire logic [fir_iq_pkg::IDX_W-1:0]         i_coef_index,
    input  wire logic signed [fir_iq_pkg::DATA_W-1:0] i_coef_value,
    input  wire logic signed [fir_iq_pkg::DATA_W-1:0] i_sample_i,
    input  wire logic signed [fir_iq_pkg::DATA_W-1:0] i_sample_q,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic signed [fir_iq_pkg::DATA_W-1:0]      o_out_i,
    output logic signed [fir_iq_pkg::DATA_W-1:0]      o_out_q,
    input  wire logic                                 i_cfg_we,
    input  wire logic [fir_iq_pkg::CNT_W-1:0]         i_cfg_wdata
);
    import fir_iq_pkg::*;

    localparam int unsigned AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int unsigned NW = $clog2(MAX_TAPS + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MOD   = 3'd1;
    localparam logic [2:0] ST_WR    = 3'd2;
    localparam logic [2:0] ST_MAC   = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]               r_state;
    logic [2:0]               n_state;
    logic [CNT_W-1:0]         r_tap_count;
    logic [AW-1:0]            r_wp;       // write position
    logic [AW-1:0]            r_sh;       // position bits fed to the modulo
    logic [NW-1:0]            r_rem;      // modulo remainder, then the position
    logic [NW-1:0]            r_k;        // step / tap counter
    logic [AW-1:0]            r_idx;      // history read index
    logic                     r_issue;    // a read was issued last cycle
    logic signed [DATA_W-1:0] r_smp_i;
    logic signed [DATA_W-1:0] r_smp_q;
    logic                     r_out_vld;
    logic signed [DATA_W-1:0] r_out_i;
    logic signed [DATA_W-1:0] r_out_q;

    logic [NW-1:0]            w_n;
    logic [NW-1:0]            w_nm1;
    logic [NW:0]              w_trial;
    logic                     w_ge;
    logic [NW-1:0]            w_rem_nx;
    logic [NW-1:0]            w_idx_inc;
    logic [AW-1:0]            w_pos;
    logic                     w_in_acc;
    logic                     w_ld_ok;
    logic [AW+IDX_W-1:0]      w_cidx_ext;
    logic                     w_out_free;
    t_mac_ctl                 w_ctl;
    logic                     w_mac_busy;
    logic signed [DATA_W-1:0] w_tap;
    logic signed [DATA_W-1:0] w_hist_i;
    logic signed [DATA_W-1:0] w_hist_q;
    logic signed [DATA_W-1:0] w_res_i;
    logic signed [DATA_W-1:0] w_res_q;

    // Effective tap count: zero acts as one, above the built depth clamps.
    always_comb begin
        if (r_tap_count == '0) begin
            w_n = NW'(1);
        end else if (32'(r_tap_count) > MAX_TAPS) begin
            w_n = NW'(MAX_TAPS);
        end else begin
            w_n = NW'(r_tap_count);
        end
    end

    assign w_nm1 = w_n - NW'(1);

    // One restoring-remainder step per cycle: wp mod n.
    assign w_trial  = {r_rem, r_sh[AW-1]};
    assign w_ge     = w_trial >= {1'b0, w_n};
    assign w_rem_nx = w_ge ? NW'(w_trial - {1'b0, w_n}) : NW'(w_trial);

    assign w_pos     = r_rem[AW-1:0];
    assign w_idx_inc = NW'(r_idx) + NW'(1);

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_cidx_ext = (AW + IDX_W)'(i_coef_index);
    assign w_ld_ok    = 32'(i_coef_index) < MAX_TAPS;
    assign w_out_free = !r_out_vld || i_out_ready;

    assign w_ctl.clear  = (r_state == ST_WR);
    assign w_ctl.rd_vld = r_issue;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc && i_op == OP_FILTER) begin
                    n_state = ST_MOD;
                end
            end
            ST_MOD: begin
                if (r_k == NW'(AW - 1)) begin
                    n_state = ST_WR;
                end
            end
            ST_WR: begin
                n_state = ST_MAC;
            end
            ST_MAC: begin
                if (r_k == w_nm1) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_issue && !w_mac_busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tap_count <= TAP_COUNT_RST;
            r_wp        <= '0;
            r_issue     <= 1'b0;
            r_out_vld   <= 1'b0;
            r_k         <= '0;
        end else begin
            r_state <= n_state;
            r_issue <= (r_state == ST_MAC);
            if (i_cfg_we) begin
                r_tap_count <= i_cfg_wdata;
            end
            if (r_state == ST_DONE && w_out_free) begin
                r_out_vld <= 1'b1;
                r_wp      <= (w_pos != '0) ? w_pos - AW'(1) : w_nm1[AW-1:0];
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (r_state == ST_MOD || r_state == ST_MAC) begin
                r_k <= (n_state == r_state) ? r_k + NW'(1) : '0;
            end else begin
                r_k <= '0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_smp_i <= i_sample_i;
            r_smp_q <= i_sample_q;
            r_sh    <= r_wp;
            r_rem   <= '0;
        end else if (r_state == ST_MOD) begin
            r_sh  <= r_sh << 1;
            r_rem <= w_rem_nx;
        end
        if (r_state == ST_WR) begin
            r_idx <= w_pos;
        end else if (r_state == ST_MAC) begin
            r_idx <= (w_idx_inc == w_n) ? '0 : w_idx_inc[AW-1:0];
        end
        if (r_state == ST_DONE && w_out_free) begin
            r_out_i <= w_res_i;
            r_out_q <= w_res_q;
        end
    end

    fir_iq_mem #(
        .MAX_TAPS (MAX_TAPS)
    ) u_mem (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tap_we       (w_in_acc && i_op == OP_LOAD && w_ld_ok),
        .i_tap_waddr    (w_cidx_ext[AW-1:0]),
        .i_tap_wdata    (i_coef_value),
        .i_hist_we      (r_state == ST_WR),
        .i_hist_waddr   (w_pos),
        .i_hist_wdata_i (r_smp_i),
        .i_hist_wdata_q (r_smp_q),
        .i_tap_raddr    (r_k[AW-1:0]),
        .i_hist_raddr   (r_idx),
        .o_tap          (w_tap),
        .o_hist_i       (w_hist_i),
        .o_hist_q       (w_hist_q)
    );

    fir_iq_mac #(
        .MAX_TAPS (MAX_TAPS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_tap    (w_tap),
        .i_hist_i (w_hist_i),
        .i_hist_q (w_hist_q),
        .o_busy   (w_mac_busy),
        .o_res_i  (w_res_i),
        .o_res_q  (w_res_q)
    );

    assign o_out_valid = r_out_vld;
    assign o_out_i     = r_out_i;
    assign o_out_q     = r_out_q;

    `FIQ_ASSERT(a_pos_in_range, i_clk, i_rst_n, r_state == ST_WR, r_rem < w_n,
                "write position not reduced below tap count")
    `FIQ_ASSERT_NEXT(a_load_one_cycle, i_clk, i_rst_n, w_in_acc && i_op == OP_LOAD,
                     r_state == ST_IDLE, "load item left the idle state")
    `FIQ_ASSERT(a_done_drained, i_clk, i_rst_n, r_state == ST_DONE,
                !r_issue && !w_mac_busy, "result taken before the MAC drained")
    `FIQ_ASSERT_NEXT(a_result_posted, i_clk, i_rst_n, r_state == ST_DONE && w_out_free,
                     o_out_valid, "finished result not posted")

endmodule

`default_nettype wire

// ----- hw/rtl/fir_iq_mem.sv -----
// Tap table and I/Q history memories with per-entry valid bits.
`default_nettype none

module fir_iq_mem #(
    parameter int unsigned MAX_TAPS = fir_iq_pkg::MAX_TAPS_DEF,
    localparam int unsigned AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_tap_we,
    input  wire logic [AW-1:0]                        i_tap_waddr,
    input  wire logic signed [fir_iq_pkg::DATA_W-1:0] i_tap_wdata,
    input  wire logic                                 i_hist_we,
    input  wire logic [AW-1:0]                        i_hist_waddr,
    input  wire logic signed [fir_iq_pkg::DATA_W-1:0] i_hist_wdata_i,
    input  wire logic signed [fir_iq_pkg::DATA_W-1:0] i_hist_wdata_q,
    input  wire logic [AW-1:0]                        i_tap_raddr,
    input  wire logic [AW-1:0]                        i_hist_raddr,
    output logic signed [fir_iq_pkg::DATA_W-1:0]      o_tap,
    output logic signed [fir_iq_pkg::DATA_W-1:0]      o_hist_i,
    output logic signed [fir_iq_pkg::DATA_W-1:0]      o_hist_q
);
    import fir_iq_pkg::*;

    logic signed [DATA_W-1:0] r_tap_mem  [MAX_TAPS];
    logic signed [DATA_W-1:0] r_hist_i_mem [MAX_TAPS];
    logic signed [DATA_W-1:0] r_hist_q_mem [MAX_TAPS];

    logic [MAX_TAPS-1:0] r_tap_vld;
    logic [MAX_TAPS-1:0] r_hist_vld;

    logic signed [DATA_W-1:0] r_tap_rd;
    logic signed [DATA_W-1:0] r_hist_i_rd;
    logic signed [DATA_W-1:0] r_hist_q_rd;
    logic                     r_tap_rv;
    logic                     r_hist_rv;

    // Valid bits: unwritten entries read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_vld  <= '0;
            r_hist_vld <= '0;
        end else begin
            if (i_tap_we) begin
                r_tap_vld[i_tap_waddr] <= 1'b1;
            end
            if (i_hist_we) begin
                r_hist_vld[i_hist_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tap_we) begin
            r_tap_mem[i_tap_waddr] <= i_tap_wdata;
        end
        if (i_hist_we) begin
            r_hist_i_mem[i_hist_waddr] <= i_hist_wdata_i;
            r_hist_q_mem[i_hist_waddr] <= i_hist_wdata_q;
        end
        r_tap_rd    <= r_tap_mem[i_tap_raddr];
        r_tap_rv    <= r_tap_vld[i_tap_raddr];
        r_hist_i_rd <= r_hist_i_mem[i_hist_raddr];
        r_hist_q_rd <= r_hist_q_mem[i_hist_raddr];
        r_hist_rv   <= r_hist_vld[i_hist_raddr];
    end

    assign o_tap    = r_tap_rv  ? r_tap_rd    : '0;
    assign o_hist_i = r_hist_rv ? r_hist_i_rd : '0;
    assign o_hist_q = r_hist_rv ? r_hist_q_rd : '0;

endmodule

`default_nettype wire

// ----- hw/rtl/fir_iq_mac.sv -----
// Shared two-lane multiply-accumulate with rounding and saturation.
`default_nettype none

`include "assert_macros.svh"

module fir_iq_mac #(
    parameter int unsigned MAX_TAPS = fir_iq_pkg::MAX_TAPS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire fir_iq_pkg::t_mac_ctl                 i_ctl,
    input  wire logic signed [fir_iq_pkg::DATA_W-1:0] i_tap,
    input  wire logic signed [fir_iq_pkg::DATA_W-1:0] i_hist_i,
    input  wire logic signed [fir_iq_pkg::DATA_W-1:0] i_hist_q,
    output logic                                      o_busy,
    output logic signed [fir_iq_pkg::DATA_W-1:0]      o_res_i,
    output logic signed [fir_iq_pkg::DATA_W-1:0]      o_res_q
);
    import fir_iq_pkg::*;

    // Headroom for MAX_TAPS full-scale products.
    localparam int unsigned ACC_W = PROD_W + $clog2(MAX_TAPS + 1);
    localparam logic signed [ACC_W-1:0] RND    = ACC_W'(16384);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(32768);

    logic signed [PROD_W-1:0] r_prod_i;
    logic signed [PROD_W-1:0] r_prod_q;
    logic                     r_prd_vld;
    logic signed [ACC_W-1:0]  r_acc_i;
    logic signed [ACC_W-1:0]  r_acc_q;

    function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] t;
        logic signed [ACC_W-1:0] q;
        t = a + RND;
        q = t >>> 15;
        if (q > SAT_HI) begin
            return DATA_W'(SAT_HI);
        end else if (q < SAT_LO) begin
            return DATA_W'(SAT_LO);
        end
        return q[DATA_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prd_vld <= 1'b0;
        end else begin
            r_prd_vld <= i_ctl.rd_vld && !i_ctl.clear;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod_i <= i_tap * i_hist_i;
        r_prod_q <= i_tap * i_hist_q;
        if (i_ctl.clear) begin
            r_acc_i <= '0;
            r_acc_q <= '0;
        end else if (r_prd_vld) begin
            r_acc_i <= r_acc_i + {{(ACC_W-PROD_W){r_prod_i[PROD_W-1]}}, r_prod_i};
            r_acc_q <= r_acc_q + {{(ACC_W-PROD_W){r_prod_q[PROD_W-1]}}, r_prod_q};
        end
    end

    assign o_busy  = r_prd_vld;
    assign o_res_i = round_sat(r_acc_i);
    assign o_res_q = round_sat(r_acc_q);

    // A clear lands only on an empty pipeline.
    `FIQ_ASSERT(a_clear_on_empty, i_clk, i_rst_n, i_ctl.clear, !i_ctl.rd_vld && !r_prd_vld, "MAC cleared with products in flight")

endmodule

`default_nettype wire

// ----- bench/fir_filter_iq_checker.sv -----
// Predicts the I/Q FIR outputs from observed traffic and compares them with the block.
`timescale 1ns / 1ps

module fir_filter_iq_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_ready,
    input  logic                                 i_op,
    input  logic [fir_iq_pkg::IDX_W-1:0]         i_coef_index,
    input  logic signed [fir_iq_pkg::DATA_W-1:0] i_coef_value,
    input  logic signed [fir_iq_pkg::DATA_W-1:0] i_sample_i,
    input  logic signed [fir_iq_pkg::DATA_W-1:0] i_sample_q,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_ready,
    input  logic signed [fir_iq_pkg::DATA_W-1:0] i_out_i,
    input  logic signed [fir_iq_pkg::DATA_W-1:0] i_out_q,
    input  logic                                 i_cfg_we,
    input  logic [fir_iq_pkg::CNT_W-1:0]         i_cfg_wdata,
    output int                                   o_mismatches,
    output int                                   o_waiting
);
    localparam int unsigned TAP_DEPTH = fir_iq_pkg::MAX_TAPS_DEF;

    typedef struct packed {
        logic signed [fir_iq_pkg::DATA_W-1:0] re;
        logic signed [fir_iq_pkg::DATA_W-1:0] im;
    } iq_pair_t;

    logic signed [fir_iq_pkg::DATA_W-1:0] coef_mem [TAP_DEPTH];
    logic signed [fir_iq_pkg::DATA_W-1:0] hist_re  [TAP_DEPTH];
    logic signed [fir_iq_pkg::DATA_W-1:0] hist_im  [TAP_DEPTH];
    logic [fir_iq_pkg::IDX_W-1:0]         head_pos;
    logic [fir_iq_pkg::CNT_W-1:0]         taps_reg;
    iq_pair_t                             filtered_q [$];
    int                                   errors = 0;

    // Round half up, drop the Q15 scale, clamp to 16 bits.
    function automatic logic signed [fir_iq_pkg::DATA_W-1:0] round_clamp(longint acc);
        longint t;
        t = (acc + 64'sd16384) >>> 15;
        if (t > 64'sd32767)
            t = 64'sd32767;
        if (t < -64'sd32768)
            t = -64'sd32768;
        return t[fir_iq_pkg::DATA_W-1:0];
    endfunction

    // One filter item: store the pair, run the MAC over n taps, step the head down.
    function automatic iq_pair_t filter_sample(logic signed [fir_iq_pkg::DATA_W-1:0] si,
                                               logic signed [fir_iq_pkg::DATA_W-1:0] sq);
        int unsigned n;
        int unsigned p;
        int unsigned idx;
        int unsigned nxt;
        longint      acc_re;
        longint      acc_im;
        iq_pair_t    r;
        if (taps_reg == 0)
            n = 1;
        else if (taps_reg > TAP_DEPTH)
            n = TAP_DEPTH;
        else
            n = taps_reg;
        p = head_pos % n;
        hist_re[p] = si;
        hist_im[p] = sq;
        acc_re = 0;
        acc_im = 0;
        idx = p;
        for (int unsigned k = 0; k < n; k++) begin
            acc_re += longint'(coef_mem[k]) * longint'(hist_re[idx]);
            acc_im += longint'(coef_mem[k]) * longint'(hist_im[idx]);
            idx = (idx + 1) % n;
        end
        nxt = (p != 0) ? p - 1 : n - 1;
        head_pos = nxt[fir_iq_pkg::IDX_W-1:0];
        r.re = round_clamp(acc_re);
        r.im = round_clamp(acc_im);
        return r;
    endfunction

    always @(posedge i_clk) begin : track
        iq_pair_t want;
        if (!i_rst_n) begin
            for (int j = 0; j < TAP_DEPTH; j++) begin
                coef_mem[j] = '0;
                hist_re[j]  = '0;
                hist_im[j]  = '0;
            end
            head_pos = '0;
            taps_reg = fir_iq_pkg::TAP_COUNT_RST;
            filtered_q.delete();
        end else begin
            if (i_cfg_we)
                taps_reg = i_cfg_wdata;
            if (i_in_valid && i_in_ready) begin
                if (i_op == fir_iq_pkg::OP_LOAD)
                    coef_mem[i_coef_index] = i_coef_value;
                else
                    filtered_q.push_back(filter_sample(i_sample_i, i_sample_q));
            end
            if (i_out_valid && i_out_ready) begin
                if (filtered_q.size() == 0) begin
                    if (errors < 10)
                        $display("%0t: result with nothing expected: i=%0d q=%0d",
                                 $realtime, i_out_i, i_out_q);
                    errors++;
                end else begin
                    want = filtered_q.pop_front();
                    if (want.re !== i_out_i || want.im !== i_out_q) begin
                        if (errors < 10)
                            $display("%0t: mismatch: expected i=%0d q=%0d, got i=%0d q=%0d",
                                     $realtime, want.re, want.im, i_out_i, i_out_q);
                        errors++;
                    end
                end
            end
        end
        o_waiting    <= filtered_q.size();
        o_mismatches <= errors;
    end

endmodule

// ----- bench/fir_filter_iq_core_tb.sv -----
// Stimulus and verdict for the I/Q FIR filter core; checking lives in the checker module.
`timescale 1ns / 1ps

module fir_filter_iq_core_tb;

    localparam int HOLD_CYCLES = 400;   // long receiver hold-off
    localparam int QUIET_LIMIT = 5000;  // watchdog: cycles with no item moving
    localparam int DRAIN_WAIT  = 100;   // covers a filter item's busy time at full depth
    localparam int PHASE_ITEMS = 90;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 i_in_valid;
    logic                                 o_in_ready;
    logic                                 i_op;
    logic [fir_iq_pkg::IDX_W-1:0]         i_coef_index;
    logic signed [fir_iq_pkg::DATA_W-1:0] i_coef_value;
    logic signed [fir_iq_pkg::DATA_W-1:0] i_sample_i;
    logic signed [fir_iq_pkg::DATA_W-1:0] i_sample_q;
    logic                                 o_out_valid;
    logic                                 i_out_ready;
    logic signed [fir_iq_pkg::DATA_W-1:0] o_out_i;
    logic signed [fir_iq_pkg::DATA_W-1:0] o_out_q;
    logic                                 i_cfg_we;
    logic [fir_iq_pkg::CNT_W-1:0]         i_cfg_wdata;

    int         chk_mismatches;
    int         chk_waiting;
    idle_mode_e idle_mode = IDLE_NONE;
    logic       hold_req  = 1'b0;

    fir_filter_iq_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_coef_index (i_coef_index),
        .i_coef_value (i_coef_value),
        .i_sample_i   (i_sample_i),
        .i_sample_q   (i_sample_q),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_i      (o_out_i),
        .o_out_q      (o_out_q),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    fir_filter_iq_checker checker_u (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_coef_index (i_coef_index),
        .i_coef_value (i_coef_value),
        .i_sample_i   (i_sample_i),
        .i_sample_q   (i_sample_q),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_i      (o_out_i),
        .i_out_q      (o_out_q),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_mismatches (chk_mismatches),
        .o_waiting    (chk_waiting)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: ready pattern follows the idle mode; a hold request parks ready
    // low for a long stretch so the output register fills and input backs up.
    initial begin : receiver
        bit held;
        held = 1'b0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !held) begin
                held = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (idle_mode == IDLE_RECV) begin
                i_out_ready <= ($urandom_range(99) >= 51);
            end else if (idle_mode == IDLE_BOTH) begin
                i_out_ready <= ($urandom_range(99) >= 10);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: any cycle that moves an item on either channel resets the count.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    // Offer one item; sender gaps (valid low) come first, then hold until taken.
    task automatic send_item(logic op, logic [fir_iq_pkg::IDX_W-1:0] idx,
                             logic signed [15:0] cv, logic signed [15:0] si,
                             logic signed [15:0] sq);
        int gap_pct;
        gap_pct = (idle_mode == IDLE_SEND) ? 51 : (idle_mode == IDLE_BOTH) ? 10 : 0;
        if ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < gap_pct)
                @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_coef_index <= idx;
        i_coef_value <= cv;
        i_sample_i   <= si;
        i_sample_q   <= sq;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Full-scale corners and zero show up often; the rest is uniform.
    function automatic logic signed [15:0] pick_value();
        case ($urandom_range(9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            default: return 16'($urandom());
        endcase
    endfunction

    // About one load per four items; fields the op ignores carry junk.
    task automatic send_random();
        logic               op;
        logic signed [15:0] sq;
        int unsigned        ci;
        op = ($urandom_range(3) == 0) ? fir_iq_pkg::OP_LOAD : fir_iq_pkg::OP_FILTER;
        sq = ($urandom_range(9) == 0) ? 16'sh0000 : pick_value();  // real-only now and then
        ci = $urandom_range(63);
        send_item(op, ci[fir_iq_pkg::IDX_W-1:0], pick_value(), pick_value(), sq);
    endtask

    // Wait out every pending result, then the pipeline tail (loads leave no trace).
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (chk_waiting != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_tap_count(logic [fir_iq_pkg::CNT_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin : stimulus
        int unsigned phase_taps [16] = '{64, 1, 2, 4, 7, 16, 0, 127,
                                         65, 33, 64, 5, 3, 1, 12, 64};
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_op         <= fir_iq_pkg::OP_FILTER;
        i_coef_index <= '0;
        i_coef_value <= '0;
        i_sample_i   <= '0;
        i_sample_q   <= '0;
        i_cfg_we     <= 1'b0;
        i_cfg_wdata  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, at the reset tap count of 64.
        // All taps zero: output must be zero whatever the samples; coef fields are junk.
        send_item(fir_iq_pkg::OP_FILTER, 6'd63, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
        // Loads at both ends of the table and at index 1 with full-scale values; sample fields junk.
        send_item(fir_iq_pkg::OP_LOAD, 6'd0, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
        send_item(fir_iq_pkg::OP_LOAD, 6'd63, 16'sh8000, 16'sh7FFF, 16'sh8000);
        send_item(fir_iq_pkg::OP_LOAD, 6'd1, 16'sh8000, 16'shFFFF, 16'sh0001);
        // Full-scale samples drive the sums into both saturation limits.
        send_item(fir_iq_pkg::OP_FILTER, 6'd5, 16'sh1234, 16'sh8000, 16'sh7FFF);
        send_item(fir_iq_pkg::OP_FILTER, 6'd0, 16'sh0000, 16'sh8000, 16'sh8000);
        send_item(fir_iq_pkg::OP_FILTER, 6'd0, 16'sh0000, 16'sh7FFF, 16'sh7FFF);
        send_item(fir_iq_pkg::OP_FILTER, 6'd0, 16'sh0000, 16'sh0000, 16'sh0000);
        send_item(fir_iq_pkg::OP_FILTER, 6'd0, 16'sh0000, 16'shFFFF, 16'sh0001);
        // Head now sits well above 3: shrinking forces the modulo on the next sample.
        settle();
        write_tap_count(7'd3);
        send_item(fir_iq_pkg::OP_FILTER, 6'd0, 16'sh0000, 16'sh7FFF, 16'sh8000);
        send_item(fir_iq_pkg::OP_FILTER, 6'd0, 16'sh0000, 16'sh8000, 16'sh8000);
        send_item(fir_iq_pkg::OP_FILTER, 6'd0, 16'sh0000, 16'sh4000, 16'shC000);
        // Tap count zero runs as a single tap.
        settle();
        write_tap_count(7'd0);
        send_item(fir_iq_pkg::OP_FILTER, 6'd0, 16'sh0000, 16'sh7FFF, 16'sh8000);
        send_item(fir_iq_pkg::OP_FILTER, 6'd0, 16'sh0000, 16'sh8000, 16'sh0000);
        // Anything above the built depth runs as the full 64 taps.
        settle();
        write_tap_count(7'd127);
        send_item(fir_iq_pkg::OP_FILTER, 6'd0, 16'sh0000, 16'sh8000, 16'sh7FFF);
        send_item(fir_iq_pkg::OP_FILTER, 6'd0, 16'sh0000, 16'sh0001, 16'shFFFF);
        send_item(fir_iq_pkg::OP_FILTER, 6'd0, 16'sh0000, 16'sh7FFF, 16'sh7FFF);

        // Random phases: tap count and idle pattern change between phases.
        for (int p = 0; p < 16; p++) begin
            settle();
            idle_mode = idle_mode_e'(p % 4);
            write_tap_count(phase_taps[p][fir_iq_pkg::CNT_W-1:0]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Back-pressure once with the sender offering flat out.
                if (p == 4 && n == 10)
                    hold_req <= 1'b1;
                send_random();
            end
        end

        settle();
        if (chk_mismatches == 0 && chk_waiting == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/fir_iq_pkg.sv
hw/rtl/fir_iq_mem.sv
hw/rtl/fir_iq_mac.sv
hw/rtl/fir_filter_iq_core.sv
bench/fir_filter_iq_checker.sv
bench/fir_filter_iq_core_tb.sv
